/* sv/polyphonic_voice_allocator_defines.svh */
// ----------------------------------------------------------------------------
// Voice allocator assertion macros
// Shared concurrent assertion forms for the voice allocator checks.
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_VOICE_ALLOCATOR_DEFINES_SVH
`define POLYPHONIC_VOICE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define PVA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("voice allocator check failed");

// next-cycle implication
`define PVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("voice allocator check failed");

`endif

/* sv/pva_pkg.sv */
// ----------------------------------------------------------------------------
// Voice allocator package
// Operation codes, field widths, states and the voice memory entry type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pva_pkg;

    localparam int OP_W    = 2;
    localparam int PITCH_W = 7;
    localparam int VEL_W   = 7;
    localparam int VOICE_W = 4;
    localparam int AGE_W   = 64;

    localparam logic [OP_W-1:0] OP_NOTE  = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TAIL,
        ST_ACT,
        ST_STEAL
    } state_t;

    typedef struct packed {
        logic [PITCH_W-1:0] pitch;
        logic [AGE_W-1:0]   age;
    } entry_t;

endpackage

/* sv/pva_voice_mem.sv */
// ----------------------------------------------------------------------------
// Voice memory
// One write port, one registered read port; holds pitch and age per voice.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pva_voice_mem #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  pva_pkg::entry_t      wdata,
    input  logic                 re,
    input  logic [ADDR_W-1:0]    raddr,
    output pva_pkg::entry_t      rdata
);

    pva_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/polyphonic_voice_allocator.sv */
// ----------------------------------------------------------------------------
// Polyphonic voice allocator
// Oldest-first voice allocation with optional stealing. Every note, stop or
// clear command scans the voice memory one entry per cycle; unused commands
// are ignored. A new command is accepted only while busy is low. Results are
// registered, appear in the cycle after they are found and cannot be
// stalled. Reset clears busy and age-valid flags and steal_enable;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polyphonic_voice_allocator #(
    parameter int VOICES = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_wdata,
    input  logic                        start,
    output logic                        busy,
    input  logic [pva_pkg::OP_W-1:0]    op,
    input  logic [pva_pkg::PITCH_W-1:0] pitch,
    input  logic [pva_pkg::VEL_W-1:0]   velocity,
    output logic                        strobe,
    output logic [pva_pkg::VOICE_W-1:0] voice,
    output logic [pva_pkg::PITCH_W-1:0] note_pitch,
    output logic [pva_pkg::VEL_W-1:0]   note_velocity,
    output logic                        last
);

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;

    pva_pkg::state_t state_reg, state_next;

    logic                        steal_reg;
    logic [VOICES-1:0]           busy_reg, busy_next;
    logic [VOICES-1:0]           written_reg, written_next;
    logic [pva_pkg::AGE_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]            rd_idx_reg, rd_idx_next;
    logic                        pv_reg;
    logic [IDX_W-1:0]            pidx_reg;

    logic [pva_pkg::OP_W-1:0]    op_reg, op_next;
    logic [pva_pkg::PITCH_W-1:0] pitch_reg, pitch_next;
    logic [pva_pkg::VEL_W-1:0]   vel_reg, vel_next;

    logic                        have_free_reg, have_free_next;
    logic [IDX_W-1:0]            free_idx_reg, free_idx_next;
    logic [pva_pkg::AGE_W-1:0]   free_age_reg, free_age_next;
    logic                        have_old_reg, have_old_next;
    logic [IDX_W-1:0]            old_idx_reg, old_idx_next;
    logic [pva_pkg::AGE_W-1:0]   old_age_reg, old_age_next;
    logic [pva_pkg::PITCH_W-1:0] old_pitch_reg, old_pitch_next;

    logic                        strobe_reg, strobe_next;
    logic [pva_pkg::VOICE_W-1:0] voice_reg;
    logic [IDX_W-1:0]            emit_idx_next;
    logic [pva_pkg::PITCH_W-1:0] note_pitch_reg, note_pitch_next;
    logic [pva_pkg::VEL_W-1:0]   note_velocity_reg, note_velocity_next;
    logic                        last_reg, last_next;

    logic                        mem_we;
    logic [IDX_W-1:0]            mem_waddr;
    pva_pkg::entry_t             mem_wdata;
    logic                        mem_re;
    pva_pkg::entry_t             mem_rdata;

    logic                        accept;
    logic                        scan_last;
    logic [pva_pkg::AGE_W-1:0]   age_eff;
    logic                        cand_old;

    assign busy      = (state_reg != pva_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign scan_last = (rd_idx_reg == IDX_W'(VOICES - 1));
    assign age_eff   = written_reg[pidx_reg] ? mem_rdata.age : pva_pkg::AGE_W'(pidx_reg);
    assign cand_old  = busy_reg[pidx_reg] &&
                       ((vel_reg != '0) || (mem_rdata.pitch == pitch_reg));
    assign mem_re    = (state_reg == pva_pkg::ST_SCAN);

    pva_voice_mem #(
        .DEPTH  (VOICES),
        .ADDR_W (IDX_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (rd_idx_reg),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steal_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            steal_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                if (accept && (op != pva_pkg::OP_NONE))
                begin
                    state_next = pva_pkg::ST_SCAN;
                end
            end
            pva_pkg::ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = pva_pkg::ST_TAIL;
                end
            end
            pva_pkg::ST_TAIL:
            begin
                state_next = (op_reg == pva_pkg::OP_NOTE) ? pva_pkg::ST_ACT
                                                          : pva_pkg::ST_IDLE;
            end
            pva_pkg::ST_ACT:
            begin
                if ((vel_reg != '0) && !have_free_reg && have_old_reg && steal_reg)
                begin
                    state_next = pva_pkg::ST_STEAL;
                end
                else
                begin
                    state_next = pva_pkg::ST_IDLE;
                end
            end
            pva_pkg::ST_STEAL:
            begin
                state_next = pva_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pva_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy_next          = busy_reg;
        written_next       = written_reg;
        cnt_next           = cnt_reg;
        rd_idx_next        = rd_idx_reg;
        op_next            = op_reg;
        pitch_next         = pitch_reg;
        vel_next           = vel_reg;
        have_free_next     = have_free_reg;
        free_idx_next      = free_idx_reg;
        free_age_next      = free_age_reg;
        have_old_next      = have_old_reg;
        old_idx_next       = old_idx_reg;
        old_age_next       = old_age_reg;
        old_pitch_next     = old_pitch_reg;
        strobe_next        = 1'b0;
        emit_idx_next      = pidx_reg;
        note_pitch_next    = mem_rdata.pitch;
        note_velocity_next = '0;
        last_next          = 1'b0;
        mem_we             = 1'b0;
        mem_waddr          = pidx_reg;
        mem_wdata          = '{pitch: mem_rdata.pitch, age: cnt_reg};

        unique case (state_reg)
            pva_pkg::ST_IDLE:
            begin
                rd_idx_next = '0;
                if (accept)
                begin
                    op_next        = op;
                    pitch_next     = pitch;
                    vel_next       = velocity;
                    have_free_next = 1'b0;
                    have_old_next  = 1'b0;
                end
            end
            pva_pkg::ST_SCAN, pva_pkg::ST_TAIL:
            begin
                rd_idx_next = rd_idx_reg + 1'b1;
                if (pv_reg)
                begin
                    case (op_reg) inside
                        pva_pkg::OP_NOTE:
                        begin
                            if (!busy_reg[pidx_reg] &&
                                (!have_free_reg || (age_eff < free_age_reg)))
                            begin
                                have_free_next = 1'b1;
                                free_idx_next  = pidx_reg;
                                free_age_next  = age_eff;
                            end
                            if (cand_old && (!have_old_reg || (age_eff < old_age_reg)))
                            begin
                                have_old_next  = 1'b1;
                                old_idx_next   = pidx_reg;
                                old_age_next   = age_eff;
                                old_pitch_next = mem_rdata.pitch;
                            end
                        end
                        pva_pkg::OP_STOP, pva_pkg::OP_CLEAR:
                        begin
                            // release this voice and restamp it
                            mem_we                 = 1'b1;
                            busy_next[pidx_reg]    = 1'b0;
                            written_next[pidx_reg] = 1'b1;
                            cnt_next               = cnt_reg + 1'b1;
                            if ((op_reg == pva_pkg::OP_STOP) && busy_reg[pidx_reg])
                            begin
                                strobe_next = 1'b1;
                                last_next   = ((busy_reg & ~(VOICES'(1) << pidx_reg)) == '0);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            pva_pkg::ST_ACT:
            begin
                if (vel_reg != '0)
                begin
                    if (have_free_reg)
                    begin
                        mem_we                     = 1'b1;
                        mem_waddr                  = free_idx_reg;
                        mem_wdata                  = '{pitch: pitch_reg, age: cnt_reg};
                        busy_next[free_idx_reg]    = 1'b1;
                        written_next[free_idx_reg] = 1'b1;
                        cnt_next                   = cnt_reg + 1'b1;
                        strobe_next                = 1'b1;
                        emit_idx_next              = free_idx_reg;
                        note_pitch_next            = pitch_reg;
                        note_velocity_next         = vel_reg;
                        last_next                  = 1'b1;
                    end
                    else if (have_old_reg && steal_reg)
                    begin
                        // release stamp only; the entry is rewritten next cycle
                        cnt_next        = cnt_reg + 1'b1;
                        strobe_next     = 1'b1;
                        emit_idx_next   = old_idx_reg;
                        note_pitch_next = old_pitch_reg;
                    end
                end
                else if (have_old_reg)
                begin
                    mem_we                    = 1'b1;
                    mem_waddr                 = old_idx_reg;
                    mem_wdata                 = '{pitch: old_pitch_reg, age: cnt_reg};
                    busy_next[old_idx_reg]    = 1'b0;
                    written_next[old_idx_reg] = 1'b1;
                    cnt_next                  = cnt_reg + 1'b1;
                    strobe_next               = 1'b1;
                    emit_idx_next             = old_idx_reg;
                    note_pitch_next           = old_pitch_reg;
                    last_next                 = 1'b1;
                end
            end
            pva_pkg::ST_STEAL:
            begin
                mem_we                    = 1'b1;
                mem_waddr                 = old_idx_reg;
                mem_wdata                 = '{pitch: pitch_reg, age: cnt_reg};
                busy_next[old_idx_reg]    = 1'b1;
                written_next[old_idx_reg] = 1'b1;
                cnt_next                  = cnt_reg + 1'b1;
                strobe_next               = 1'b1;
                emit_idx_next             = old_idx_reg;
                note_pitch_next           = pitch_reg;
                note_velocity_next        = vel_reg;
                last_next                 = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= pva_pkg::ST_IDLE;
            busy_reg    <= '0;
            written_reg <= '0;
            cnt_reg     <= pva_pkg::AGE_W'(VOICES);
            rd_idx_reg  <= '0;
            pv_reg      <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            written_reg <= written_next;
            cnt_reg     <= cnt_next;
            rd_idx_reg  <= rd_idx_next;
            pv_reg      <= (state_reg == pva_pkg::ST_SCAN);
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg          <= rd_idx_reg;
        op_reg            <= op_next;
        pitch_reg         <= pitch_next;
        vel_reg           <= vel_next;
        have_free_reg     <= have_free_next;
        free_idx_reg      <= free_idx_next;
        free_age_reg      <= free_age_next;
        have_old_reg      <= have_old_next;
        old_idx_reg       <= old_idx_next;
        old_age_reg       <= old_age_next;
        old_pitch_reg     <= old_pitch_next;
        voice_reg         <= pva_pkg::VOICE_W'({1'b0, emit_idx_next} + 1'b1);
        note_pitch_reg    <= note_pitch_next;
        note_velocity_reg <= note_velocity_next;
        last_reg          <= last_next;
    end

    assign strobe        = strobe_reg;
    assign voice         = voice_reg;
    assign note_pitch    = note_pitch_reg;
    assign note_velocity = note_velocity_reg;
    assign last          = strobe_reg & last_reg;

endmodule

/* sv/pva_checker.sv */
// ----------------------------------------------------------------------------
// Voice allocator checker
// Port-level checks on command acceptance and result sequencing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polyphonic_voice_allocator_defines.svh"

module pva_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [pva_pkg::OP_W-1:0]    op,
    input logic                        strobe,
    input logic [pva_pkg::VEL_W-1:0]   note_velocity,
    input logic                        last
);

    `PVA_ASSERT_NEXT(a_unused_op_ignored, clk, rst_n, start && !busy && (op == pva_pkg::OP_NONE), !busy)
    `PVA_ASSERT_NEXT(a_note_goes_busy, clk, rst_n, start && !busy && (op == pva_pkg::OP_NOTE), busy)
    `PVA_ASSERT_NEXT(a_final_then_quiet, clk, rst_n, strobe && last, !strobe)
    `PVA_ASSERT_IMPLY(a_note_on_is_final, clk, rst_n, strobe && (note_velocity != '0), last)

endmodule

bind polyphonic_voice_allocator pva_checker u_pva_checker (.*);

/* tb/sv/polyphonic_voice_allocator_tb.sv */
// ----------------------------------------------------------------------------
// Polyphonic voice allocator testbench
// Drives note, stop, clear and unused commands through the start/busy port.
// A voice pool model predicts the note-on and note-off results, including
// stealing and the oldest-first choice. Every strobed result is compared
// field by field in order. A directed opening is followed by random phases
// that switch steal_enable and vary the gaps between commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polyphonic_voice_allocator_tb;
    import pva_pkg::*;

    localparam int VOICES       = 8;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 16;
    localparam int RANDOM_ITEMS = 250;
    localparam int PHASES       = 5;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [PITCH_W-1:0] pitch;
        logic [VEL_W-1:0]   vel;
        logic               last;
    } note_t;

    class voice_pool_model;
        bit                steal_on;
        bit                held[VOICES];
        bit [PITCH_W-1:0]  held_pitch[VOICES];
        bit [AGE_W-1:0]    age[VOICES];
        bit [AGE_W-1:0]    age_next;
        note_t             expected_notes[$];
        int                errors;
        int                items;
        int                results;
        int                steals;
        int                dropped;

        function new();
            steal_on = 1'b0;
            for (int i = 0; i < VOICES; i++)
            begin
                held[i]       = 1'b0;
                held_pitch[i] = '0;
                age[i]        = AGE_W'(i);
            end
            age_next = AGE_W'(VOICES);
            errors   = 0;
            items    = 0;
            results  = 0;
            steals   = 0;
            dropped  = 0;
        endfunction

        function void stamp_voice(int v);
            age[v]   = age_next;
            age_next = age_next + 1'b1;
        endfunction

        function void push_note(int v, bit [PITCH_W-1:0] p, bit [VEL_W-1:0] vel);
            note_t n;
            n.voice = VOICE_W'(v + 1);
            n.pitch = p;
            n.vel   = vel;
            n.last  = 1'b0;
            expected_notes.push_back(n);
        endfunction

        function int free_voice(int v, bit report);
            bit was;
            was     = held[v];
            held[v] = 1'b0;
            stamp_voice(v);
            if (report && was)
            begin
                push_note(v, held_pitch[v], '0);
                return 1;
            end
            return 0;
        endfunction

        function int start_voice(int v, bit [PITCH_W-1:0] p, bit [VEL_W-1:0] vel);
            held_pitch[v] = p;
            held[v]       = 1'b1;
            stamp_voice(v);
            push_note(v, p, vel);
            return 1;
        endfunction

        function void predict_notes(logic [OP_W-1:0] o, logic [PITCH_W-1:0] p,
                                    logic [VEL_W-1:0] vel);
            int    k;
            int    fi;
            int    bi;
            bit    have_free;
            bit    have_busy;
            note_t n;
            k         = 0;
            fi        = 0;
            bi        = 0;
            have_free = 1'b0;
            have_busy = 1'b0;
            case (o)
                OP_NOTE:
                begin
                    if (vel != 0)
                    begin
                        for (int i = 0; i < VOICES; i++)
                        begin
                            if (held[i])
                            begin
                                if (!have_busy || age[i] < age[bi])
                                begin
                                    have_busy = 1'b1;
                                    bi        = i;
                                end
                            end
                            else if (!have_free || age[i] < age[fi])
                            begin
                                have_free = 1'b1;
                                fi        = i;
                            end
                        end
                        if (have_free)
                            k += start_voice(fi, p, vel);
                        else if (have_busy && steal_on)
                        begin
                            k += free_voice(bi, 1'b1);
                            k += start_voice(bi, p, vel);
                            steals++;
                        end
                        else
                            dropped++;
                    end
                    else
                    begin
                        for (int i = 0; i < VOICES; i++)
                        begin
                            if (held[i] && held_pitch[i] == p &&
                                (!have_busy || age[i] < age[bi]))
                            begin
                                have_busy = 1'b1;
                                bi        = i;
                            end
                        end
                        if (have_busy)
                            k += free_voice(bi, 1'b1);
                    end
                end
                OP_STOP:
                begin
                    for (int i = 0; i < VOICES; i++)
                        k += free_voice(i, 1'b1);
                end
                OP_CLEAR:
                begin
                    for (int i = 0; i < VOICES; i++)
                        void'(free_voice(i, 1'b0));
                end
                default:
                begin
                end
            endcase
            if (k > 0)
            begin
                n      = expected_notes.pop_back();
                n.last = 1'b1;
                expected_notes.push_back(n);
            end
            items++;
            results += k;
        endfunction

        function void check_note(logic [VOICE_W-1:0] v, logic [PITCH_W-1:0] p,
                                 logic [VEL_W-1:0] vel, logic l);
            note_t n;
            if (expected_notes.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result voice %0d pitch %0d velocity %0d last %0d",
                         $time, v, p, vel, l);
                return;
            end
            n = expected_notes.pop_front();
            if (v !== n.voice)
            begin
                errors++;
                $display("%0t: voice expected %0d actual %0d", $time, n.voice, v);
            end
            if (p !== n.pitch)
            begin
                errors++;
                $display("%0t: note_pitch expected %0d actual %0d", $time, n.pitch, p);
            end
            if (vel !== n.vel)
            begin
                errors++;
                $display("%0t: note_velocity expected %0d actual %0d", $time, n.vel, vel);
            end
            if (l !== n.last)
            begin
                errors++;
                $display("%0t: last expected %0d actual %0d", $time, n.last, l);
            end
        endfunction
    endclass

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_wdata = 1'b0;
    logic               start     = 1'b0;
    logic               busy;
    logic [OP_W-1:0]    op        = OP_NOTE;
    logic [PITCH_W-1:0] pitch     = '0;
    logic [VEL_W-1:0]   velocity  = '0;
    logic               strobe;
    logic [VOICE_W-1:0] voice;
    logic [PITCH_W-1:0] note_pitch;
    logic [VEL_W-1:0]   note_velocity;
    logic               last;

    voice_pool_model pool = new();
    int              idle_cycles = 0;
    int              steal_writes = 0;
    bit              no_gaps = 1'b0;

    polyphonic_voice_allocator #(
        .VOICES(VOICES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .start        (start),
        .busy         (busy),
        .op           (op),
        .pitch        (pitch),
        .velocity     (velocity),
        .strobe       (strobe),
        .voice        (voice),
        .note_pitch   (note_pitch),
        .note_velocity(note_velocity),
        .last         (last)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            pool.check_note(voice, note_pitch, note_velocity, last);
    end

    always @(posedge clk)
    begin
        if (strobe || (start && !busy))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, pool.expected_notes.size());
            $display("polyphonic_voice_allocator_tb: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_item(input logic [OP_W-1:0] o, input logic [PITCH_W-1:0] p,
                             input logic [VEL_W-1:0] v);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        op       <= o;
        pitch    <= p;
        velocity <= v;
        do
            @(posedge clk);
        while (busy);
        pool.predict_notes(o, p, v);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pool.expected_notes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_steal(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        pool.steal_on = v;
        steal_writes++;
    endtask

    task automatic random_phase(input int count);
        int                 sent;
        int                 roll;
        int                 vi;
        logic [PITCH_W-1:0] p;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 19) == 0)
                no_gaps = !no_gaps;
            roll = $urandom_range(0, 99);
            if (roll < 55)
            begin
                if ($urandom_range(0, 2) == 0)
                    p = PITCH_W'($urandom_range(60, 63));
                else
                    p = PITCH_W'($urandom_range(0, 127));
                send_item(OP_NOTE, p, VEL_W'($urandom_range(1, 127)));
            end
            else if (roll < 87)
            begin
                vi = $urandom_range(0, VOICES - 1);
                if (pool.held[vi] && $urandom_range(0, 3) != 0)
                    p = pool.held_pitch[vi];
                else
                    p = PITCH_W'($urandom_range(0, 127));
                send_item(OP_NOTE, p, '0);
            end
            else if (roll < 92)
                send_item(OP_STOP, PITCH_W'($urandom), VEL_W'($urandom));
            else if (roll < 96)
                send_item(OP_CLEAR, PITCH_W'($urandom), VEL_W'($urandom));
            else
            begin
                send_item(OP_NONE, PITCH_W'($urandom), VEL_W'($urandom));
                continue;
            end
            sent++;
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_steal(1'b0);

        send_item(OP_NOTE, 7'd60, 7'd0);
        send_item(OP_NOTE, 7'd0, 7'd127);
        send_item(OP_NOTE, 7'd127, 7'd1);
        send_item(OP_NOTE, 7'd60, 7'd64);
        send_item(OP_NOTE, 7'd60, 7'd100);
        send_item(OP_NOTE, 7'd85, 7'd42);
        send_item(OP_NOTE, 7'd42, 7'd85);
        send_item(OP_NOTE, 7'd1, 7'd126);
        send_item(OP_NOTE, 7'd126, 7'd2);
        // pool full, stealing off: drop
        send_item(OP_NOTE, 7'd99, 7'd99);
        send_item(OP_NOTE, 7'd60, 7'd0);
        send_item(OP_NONE, 7'd127, 7'd127);
        settle();
        write_steal(1'b1);
        send_item(OP_NOTE, 7'd77, 7'd77);
        send_item(OP_NOTE, 7'd33, 7'd55);
        send_item(OP_NOTE, 7'd34, 7'd56);
        send_item(OP_STOP, 7'd0, 7'd0);
        send_item(OP_STOP, 7'd127, 7'd127);
        send_item(OP_NOTE, 7'd5, 7'd5);
        send_item(OP_CLEAR, 7'h55, 7'h2a);
        send_item(OP_NOTE, 7'd5, 7'd0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            write_steal(ph % 2 == 0);
            random_phase(RANDOM_ITEMS / PHASES);
        end
        settle();

        if (pool.expected_notes.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time,
                     pool.expected_notes.size());
            pool.errors += pool.expected_notes.size();
        end
        $display("run covered %0d commands and %0d results: %0d steals, %0d dropped notes",
                 pool.items, pool.results, pool.steals, pool.dropped);
        $display("steal_enable written %0d times, %0d mismatches", steal_writes, pool.errors);
        if (pool.errors == 0)
            $display("polyphonic_voice_allocator_tb: clean");
        else
            $display("polyphonic_voice_allocator_tb: errors");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/pva_pkg.sv
sv/pva_voice_mem.sv
sv/polyphonic_voice_allocator.sv
sv/pva_checker.sv
tb/sv/polyphonic_voice_allocator_tb.sv
